// ===== hdl/sodbr_pkg.sv =====
// Shared types and constants for the send-on-delta batch reporter.
// Used by the controller, the datapath and the top level; no dependencies.
package sodbr_pkg;

  localparam int BATCH_DEPTH = 10;
  localparam int ADDR_W = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;

  localparam int TEMP_W = 11;
  localparam int HUM_W = 10;
  localparam int PCT_W = 7;
  localparam int TIME_W = 32;
  localparam int ENTRY_W = TEMP_W + HUM_W + PCT_W + TIME_W;

  localparam int LAST_TH_W = 15;
  localparam int LAST_PCT_W = 11;

  localparam logic signed [LAST_TH_W-1:0] SENTINEL_TH = -15'sd10000;
  localparam logic signed [LAST_PCT_W-1:0] SENTINEL_PCT = -11'sd1000;

  localparam logic [9:0] RST_TEMP_DB = 10'd5;
  localparam logic [9:0] RST_HUM_DB = 10'd20;
  localparam logic [6:0] RST_PCT_DB = 7'd5;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_DB = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PCT_DB = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic qualify;
    logic fill_last;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/sodbr_ctrl.sv =====
// Controller state machine of the send-on-delta batch reporter.
// Depends on sodbr_pkg; drives commands to sodbr_datapath.
module sodbr_ctrl import sodbr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && status.qualify && status.fill_last) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          state_nxt = status.rd_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.accept = in_valid;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_LOAD: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/sodbr_datapath.sv =====
// Datapath of the send-on-delta batch reporter: deadband registers, last
// reported values, batch store and output register. Depends on sodbr_pkg.
module sodbr_datapath import sodbr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [TEMP_W-1:0]  in_temperature_tenths,
  input  logic [HUM_W-1:0]          in_humidity_tenths,
  input  logic [PCT_W-1:0]          in_knob_percent,
  input  logic [TIME_W-1:0]         in_time_stamp,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [TEMP_W-1:0]  out_temperature,
  output logic [HUM_W-1:0]          out_humidity,
  output logic [PCT_W-1:0]          out_percent,
  output logic [TIME_W-1:0]         out_time,
  output logic                      out_last_of_batch
);

  logic [9:0] temp_db_r;
  logic [9:0] hum_db_r;
  logic [6:0] pct_db_r;

  logic signed [LAST_TH_W-1:0]  last_temp_r;
  logic signed [LAST_TH_W-1:0]  last_hum_r;
  logic signed [LAST_PCT_W-1:0] last_pct_r;

  logic [ADDR_W-1:0] fill_r;
  logic [ADDR_W-1:0] fill_nxt;
  logic [ADDR_W-1:0] rd_idx_r;
  logic [ADDR_W-1:0] rd_idx_nxt;

  logic [ENTRY_W-1:0] mem [BATCH_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  logic out_valid_r;
  logic out_valid_nxt;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic [HUM_W-1:0]         out_hum_r;
  logic [PCT_W-1:0]         out_pct_r;
  logic [TIME_W-1:0]        out_time_r;
  logic                     out_last_r;

  logic signed [16:0] d_temp;
  logic signed [16:0] d_hum;
  logic signed [12:0] d_pct;
  logic [16:0] a_temp;
  logic [16:0] a_hum;
  logic [12:0] a_pct;
  logic q_temp;
  logic q_hum;
  logic q_pct;
  logic store_we;

  always_comb begin
    d_temp = 17'(in_temperature_tenths) - 17'(last_temp_r);
    d_hum = $signed({7'b0, in_humidity_tenths}) - 17'(last_hum_r);
    d_pct = $signed({6'b0, in_knob_percent}) - 13'(last_pct_r);
    a_temp = d_temp[16] ? 17'(-d_temp) : 17'(d_temp);
    a_hum = d_hum[16] ? 17'(-d_hum) : 17'(d_hum);
    a_pct = d_pct[12] ? 13'(-d_pct) : 13'(d_pct);
    q_temp = a_temp >= {7'b0, temp_db_r};
    q_hum = a_hum >= {7'b0, hum_db_r};
    q_pct = a_pct >= {6'b0, pct_db_r};
  end

  assign store_we = cmd.accept && (q_temp || q_hum || q_pct);

  assign status.qualify = q_temp || q_hum || q_pct;
  assign status.fill_last = (fill_r == ADDR_W'(BATCH_DEPTH - 1));
  assign status.rd_last = (rd_idx_r == ADDR_W'(BATCH_DEPTH - 1));
  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_db_r <= RST_TEMP_DB;
      hum_db_r <= RST_HUM_DB;
      pct_db_r <= RST_PCT_DB;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_DB: temp_db_r <= cfg_data;
        CFG_HUM_DB: hum_db_r <= cfg_data;
        CFG_PCT_DB: pct_db_r <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_temp_r <= SENTINEL_TH;
      last_hum_r <= SENTINEL_TH;
      last_pct_r <= SENTINEL_PCT;
    end else if (store_we) begin
      if (q_temp) begin
        last_temp_r <= LAST_TH_W'(in_temperature_tenths);
      end
      if (q_hum) begin
        last_hum_r <= $signed({5'b0, in_humidity_tenths});
      end
      if (q_pct) begin
        last_pct_r <= $signed({4'b0, in_knob_percent});
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (store_we) begin
      fill_nxt = status.fill_last ? '0 : fill_r + 1'b1;
    end
    rd_idx_nxt = rd_idx_r;
    if (cmd.load_out) begin
      rd_idx_nxt = status.rd_last ? '0 : rd_idx_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      rd_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      rd_idx_r <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      mem[fill_r] <= {in_temperature_tenths, in_humidity_tenths, in_knob_percent,
                      in_time_stamp};
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_temp_r <= $signed(rdata_r[ENTRY_W-1 -: TEMP_W]);
      out_hum_r <= rdata_r[PCT_W+TIME_W +: HUM_W];
      out_pct_r <= rdata_r[TIME_W +: PCT_W];
      out_time_r <= rdata_r[TIME_W-1:0];
      out_last_r <= status.rd_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_temperature = out_temp_r;
  assign out_humidity = out_hum_r;
  assign out_percent = out_pct_r;
  assign out_time = out_time_r;
  assign out_last_of_batch = out_last_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < ADDR_W'(BATCH_DEPTH))
    else $error("batch fill count out of range");

  a_batch_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (store_we && status.fill_last) |=> (fill_r == '0))
    else $error("fill count did not restart after a full batch");

  a_no_store_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en || cmd.load_out) |-> !store_we)
    else $error("batch store written while draining");

endmodule

// ===== hdl/send_on_delta_batch_reporter_unit.sv =====
// Top level of the send-on-delta batch reporter: joins controller and datapath.
// Depends on sodbr_pkg, sodbr_ctrl and sodbr_datapath.
//
// Each accepted reading is compared per channel against the last reported value;
// when any channel moves by at least its deadband the reading goes into a
// ten-entry batch store. The input is not stalled while the block is
// collecting. When the tenth reading is stored, the block stalls its input and
// drains the batch: each result is read from the store and then loaded into the
// output register, waiting while the output side stalls. Configuration writes
// are always ready.
module send_on_delta_batch_reporter_unit import sodbr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [TEMP_W-1:0]  in_temperature_tenths,
  input  logic [HUM_W-1:0]          in_humidity_tenths,
  input  logic [PCT_W-1:0]          in_knob_percent,
  input  logic [TIME_W-1:0]         in_time_stamp,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [TEMP_W-1:0]  out_temperature,
  output logic [HUM_W-1:0]          out_humidity,
  output logic [PCT_W-1:0]          out_percent,
  output logic [TIME_W-1:0]         out_time,
  output logic                      out_last_of_batch,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  sodbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sodbr_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_temperature_tenths (in_temperature_tenths),
    .in_humidity_tenths    (in_humidity_tenths),
    .in_knob_percent       (in_knob_percent),
    .in_time_stamp         (in_time_stamp),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_temperature       (out_temperature),
    .out_humidity          (out_humidity),
    .out_percent           (out_percent),
    .out_time              (out_time),
    .out_last_of_batch     (out_last_of_batch)
  );

endmodule
